[rtl/mndp_pkg.sv]
package mndp_pkg;

  // field widths
  localparam int FUNC_W  = 2;
  localparam int TRACK_W = 2;
  localparam int KIND_W  = 2;
  localparam int CHAN_W  = 4;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int BEAT_W  = 32;
  localparam int LEN_W   = 16;

  // item functions
  localparam logic [FUNC_W-1:0] FUNC_ARM   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINAL = 2'd2;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_ON  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFF = 2'd1;

  // result status
  localparam logic STATUS_NOTE = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  // one active note slot
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [BEAT_W-1:0] start;
  } entry_t;

  // closing beat, or start plus minimum length saturated to all ones
  function automatic logic [BEAT_W-1:0] close_end(input logic [BEAT_W-1:0] start_b,
                                                  input logic [BEAT_W-1:0] at_b,
                                                  input logic [LEN_W-1:0] min_len);
    logic [BEAT_W:0] sum;
    sum = {1'b0, start_b} + {{(BEAT_W + 1 - LEN_W){1'b0}}, min_len};
    if (at_b > start_b) begin
      close_end = at_b;
    end else if (sum[BEAT_W]) begin
      close_end = '1;
    end else begin
      close_end = sum[BEAT_W-1:0];
    end
  endfunction

endpackage

[rtl/midi_note_duration_pairing.sv]
// Timing: arm and ignored items never raise busy; events and finalize items
// on an armed track keep busy high while the scan reads every slot of the track,
// one slot a cycle through the single read port of the slot memory, then
// through the closing step; the last result strobes in the cycle that busy falls.
// No new item is taken while busy is high; results cannot stall.
// Reset: all tracks disarmed, all slots empty, minimum length 1/16 beat.
module midi_note_duration_pairing #(
  parameter int TRACKS             = 4,
  parameter int ACTIVE_SLOTS       = 32,
  parameter int BEAT_FRACTION_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [mndp_pkg::FUNC_W-1:0]     func,
  input  logic [mndp_pkg::TRACK_W-1:0]    track,
  input  logic [mndp_pkg::KIND_W-1:0]     event_kind,
  input  logic [mndp_pkg::CHAN_W-1:0]     channel,
  input  logic [mndp_pkg::NOTE_W-1:0]     note_number,
  input  logic [mndp_pkg::VEL_W-1:0]      velocity,
  input  logic [mndp_pkg::BEAT_W-1:0]     beat_pos,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mndp_pkg::LEN_W-1:0]      cfg_data,
  output logic                            strobe,
  output logic                            status,
  output logic [mndp_pkg::TRACK_W-1:0]    out_track,
  output logic [mndp_pkg::CHAN_W-1:0]     out_channel,
  output logic [mndp_pkg::NOTE_W-1:0]     out_note,
  output logic [mndp_pkg::VEL_W-1:0]      out_velocity,
  output logic [mndp_pkg::BEAT_W-1:0]     start_beat,
  output logic [mndp_pkg::BEAT_W-1:0]     end_beat,
  output logic                            last
);
  import mndp_pkg::*;

  localparam int SLOT_TOTAL = TRACKS * ACTIVE_SLOTS;
  localparam int AW = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int SW = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int IW = $clog2(ACTIVE_SLOTS + 1);
  localparam logic [LEN_W-1:0] MIN_LEN_RST = LEN_W'((1 << BEAT_FRACTION_BITS) >> 4);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_END  = 2'd2;

  logic [1:0]              state;
  logic [LEN_W-1:0]        min_len;
  logic [TRACKS-1:0]       track_armed;
  logic [SLOT_TOTAL-1:0]   slot_valid;
  entry_t                  slot_mem [SLOT_TOTAL];

  // latched item
  logic [FUNC_W-1:0]       func_q;
  logic [TRACK_W-1:0]      trk_q;
  logic [KIND_W-1:0]       kind_q;
  logic [CHAN_W-1:0]       ch_q;
  logic [NOTE_W-1:0]       nt_q;
  logic [VEL_W-1:0]        vel_q;
  logic [BEAT_W-1:0]       beat_q;

  // scan pipeline
  logic [IW-1:0]           idx;
  logic                    p_live;
  logic                    p_act;
  logic [SW-1:0]           p_idx;
  entry_t                  rd_q;

  // held note and first free slot
  logic                    pend_v;
  entry_t                  pend;
  logic [BEAT_W-1:0]       pend_end;
  logic [SW-1:0]           pend_idx;
  logic                    free_v;
  logic [SW-1:0]           free_idx;

  logic                    accept;
  logic [TW-1:0]           in_tidx;
  logic [TW-1:0]           tidx;
  logic [AW-1:0]           base;
  logic [AW-1:0]           in_base;
  logic                    idx_live;
  logic [SW-1:0]           slot;
  logic [AW-1:0]           scan_addr;
  logic                    is_final;
  logic                    note_on;
  logic                    hit;
  logic                    mem_we;
  logic [SW-1:0]           wr_slot;
  logic [AW-1:0]           wr_addr;
  logic                    emit_pend;
  logic                    emit_drop;
  logic                    emit_last;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // slot addressing
  assign in_tidx   = TW'(track);
  assign tidx      = TW'(trk_q);
  assign in_base   = AW'(in_tidx) * AW'(ACTIVE_SLOTS);
  assign base      = AW'(tidx) * AW'(ACTIVE_SLOTS);
  assign idx_live  = (idx != IW'(ACTIVE_SLOTS));
  assign slot      = idx[SW-1:0];
  assign scan_addr = base + AW'(slot);

  assign is_final  = (func_q == FUNC_FINAL);
  assign note_on   = (kind_q == KIND_ON) && (vel_q != '0);

  // slot found in the entry just read
  assign hit = p_live && p_act &&
               (is_final || (!pend_v && rd_q.channel == ch_q && rd_q.note == nt_q));

  // closing step
  assign wr_slot   = pend_v ? pend_idx : free_idx;
  assign wr_addr   = base + AW'(wr_slot);
  assign mem_we    = (state == S_END) && !is_final && note_on && (pend_v || free_v);
  assign emit_last = (state == S_END) && pend_v && (is_final || !note_on);
  assign emit_drop = (state == S_END) && !is_final && note_on && !pend_v && !free_v;
  assign emit_pend = ((state == S_SCAN) && hit && pend_v) || emit_last;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      min_len     <= MIN_LEN_RST;
      track_armed <= '0;
      slot_valid  <= '0;
      strobe      <= 1'b0;
      p_live      <= 1'b0;
      pend_v      <= 1'b0;
      free_v      <= 1'b0;
      idx         <= '0;
    end else begin
      strobe <= emit_pend || emit_drop;
      if (cfg_valid && cfg_ready) begin
        min_len <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          idx    <= '0;
          p_live <= 1'b0;
          pend_v <= 1'b0;
          free_v <= 1'b0;
          if (accept && (32'(track) < TRACKS)) begin
            if (func == FUNC_ARM) begin
              slot_valid[in_base +: ACTIVE_SLOTS] <= '0;
              track_armed[in_tidx] <= 1'b1;
            end else if (track_armed[in_tidx] &&
                         ((func == FUNC_FINAL) ||
                          (func == FUNC_EVENT &&
                           (event_kind == KIND_ON || event_kind == KIND_OFF)))) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // issue side
          p_live <= idx_live;
          if (idx_live) begin
            p_act <= slot_valid[scan_addr];
            p_idx <= slot;
            idx   <= idx + 1'b1;
          end else if (!p_live) begin
            state <= S_END;
          end
          // evaluate side
          if (hit) begin
            pend_v <= 1'b1;
            if (is_final) begin
              slot_valid[base + AW'(p_idx)] <= 1'b0;
            end
          end
          if (p_live && !p_act && !free_v) begin
            free_v <= 1'b1;
          end
        end
        S_END: begin
          if (is_final) begin
            track_armed[tidx] <= 1'b0;
          end else if (mem_we) begin
            slot_valid[wr_addr] <= 1'b1;
          end else if (emit_last) begin
            slot_valid[base + AW'(pend_idx)] <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item latch and scan payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      trk_q  <= track;
      kind_q <= event_kind;
      ch_q   <= channel;
      nt_q   <= note_number;
      vel_q  <= velocity;
      beat_q <= beat_pos;
    end
    if ((state == S_SCAN) && hit) begin
      pend     <= rd_q;
      pend_end <= close_end(rd_q.start, beat_q, min_len);
      pend_idx <= p_idx;
    end
    if ((state == S_SCAN) && p_live && !p_act && !free_v) begin
      free_idx <= p_idx;
    end
  end

  // slot memory, one port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= '{channel: ch_q, note: nt_q, velocity: vel_q, start: beat_q};
    end
    if ((state == S_SCAN) && idx_live) begin
      rd_q <= slot_mem[scan_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_pend) begin
      status       <= STATUS_NOTE;
      out_track    <= trk_q;
      out_channel  <= pend.channel;
      out_note     <= pend.note;
      out_velocity <= pend.velocity;
      start_beat   <= pend.start;
      end_beat     <= pend_end;
      last         <= emit_last;
    end else if (emit_drop) begin
      status       <= STATUS_DROP;
      out_track    <= trk_q;
      out_channel  <= ch_q;
      out_note     <= nt_q;
      out_velocity <= vel_q;
      start_beat   <= beat_q;
      end_beat     <= '0;
      last         <= 1'b1;
    end
  end

endmodule

[rtl/mndp_check.sv]
module mndp_check (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic status,
  input logic last
);
  import mndp_pkg::*;

  // a dropped note is always the only result of its item
  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && status == STATUS_DROP) |-> last)
    else $error("dropped note result without last");

  // a result that is not the last one arrives while the scan still runs
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("non-final result while idle");

  // nothing follows the last result of an item in the next cycle
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("result straight after last");

  // no result in the cycle after an item is taken
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !strobe)
    else $error("result right after accept");

  // reset leaves the block idle and silent
  a_reset: assert property (@(posedge clk)
    rst |=> (!busy && !strobe))
    else $error("busy or strobe after reset");

endmodule

bind midi_note_duration_pairing mndp_check u_mndp_check (.*);
